[src/lfia_pkg.sv]
// Shared constants, codes and helper functions for the lowest free ID allocator.
// Used by the allocator core; depends on nothing else.
`default_nettype none
package lfia_pkg;

  // Pool geometry
  localparam int POOL_SIZE = 1024;
  localparam int WORD_W    = 32;
  localparam int NWORDS    = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int OFF_W     = WIDX_W + BIT_W;
  localparam int ID_W      = 31;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // Base ID after reset
  localparam logic [ID_W-1:0] BASE_RESET = ID_W'(1);

  typedef enum logic {
    S_IDLE,
    S_MOD
  } state_t;

  typedef logic [WORD_W-1:0] row_t;
  typedef logic [NWORDS-1:0] summary_t;

  // Lowest set bit of a bitmap word (0 when the word is empty)
  function automatic logic [BIT_W-1:0] low_bit(input row_t v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Lowest non-empty word in the summary (0 when none)
  function automatic logic [WIDX_W-1:0] low_word(input summary_t v);
    logic [WIDX_W-1:0] r;
    r = '0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WIDX_W'(i);
    end
    return r;
  endfunction

  // Reset contents of a bitmap word: every ID that exists is free
  function automatic row_t row_reset(input logic [WIDX_W-1:0] w);
    int left;
    row_t r;
    left = POOL_SIZE - int'(w) * WORD_W;
    if (left >= WORD_W) r = '1;
    else r = (row_t'(1) << left) - row_t'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

[src/lfia_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read data.
// Holds the free bitmap words; no package dependencies.
`default_nettype none
module lfia_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/lowest_free_id_allocator_core.sv]
// Top level of the lowest free ID allocator: request decode, bitmap update, result word.
// Depends on lfia_pkg and lfia_ram.
`default_nettype none
// A request is accepted, then updated. In the accept cycle the pool offset (free) or the
// lowest non-empty word from the summary register (allocate) is found and the bitmap word
// is read from the single-port-read RAM; in the update state the word is updated and
// written back and the result word is loaded into the output register once the output
// side can take it. No new request is taken until that load has happened. Bitmap words
// not yet written since reset read as all free, so no clearing pass runs after reset.
// Writing base_id moves the whole pool, used and free IDs alike; the user must do it
// only while the block is idle, as the block itself does not enforce this.
module lowest_free_id_allocator_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [lfia_pkg::ID_W-1:0] cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      kind,
  input  wire logic [lfia_pkg::ID_W-1:0] id,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [lfia_pkg::ID_W-1:0] result_id,
  output logic      [1:0]                status
);
  import lfia_pkg::*;

  state_t state, state_next;

  logic [ID_W-1:0]   base_id;
  summary_t          summary;
  summary_t          row_valid;

  logic              kind_q;
  logic              miss_q;
  logic [WIDX_W-1:0] word_q;
  logic [BIT_W-1:0]  bit_q;

  logic              in_take;
  logic              out_load;
  logic [ID_W-1:0]   in_off;
  logic              in_miss;
  logic [WIDX_W-1:0] in_word;
  logic [BIT_W-1:0]  in_bit;

  logic [WIDX_W-1:0] ram_raddr;
  row_t              ram_rdata;
  logic              ram_we;
  row_t              row_cur;
  row_t              row_new;
  logic [BIT_W-1:0]  alloc_bit;
  logic              already_free;
  logic [ID_W-1:0]   alloc_id;
  logic [1:0]        status_next;
  logic [ID_W-1:0]   result_next;

  // Base register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_id <= BASE_RESET;
    end else if (cfg_wr_en) begin
      base_id <= cfg_wr_data;
    end
  end

  // Decode the incoming request
  assign in_take = in_valid && !in_stall;
  assign in_off  = id - base_id;
  always_comb begin
    if (kind == KIND_ALLOC) begin
      in_word = low_word(summary);
      in_bit  = '0;
      in_miss = (summary == '0);
    end else begin
      in_word = in_off[OFF_W-1:BIT_W];
      in_bit  = in_off[BIT_W-1:0];
      in_miss = (in_off >= ID_W'(POOL_SIZE));
    end
  end

  // Hold the decoded request for the update cycle
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_q <= kind;
      miss_q <= in_miss;
      word_q <= in_word;
      bit_q  <= in_bit;
    end
  end

  // Bitmap storage; keep re-reading the held word while the output stalls
  assign ram_raddr = (state == S_IDLE) ? in_word : word_q;

  lfia_ram #(
    .DEPTH (NWORDS),
    .WIDTH (WORD_W),
    .AW    (WIDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_q),
    .wdata (row_new),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Modify the bitmap word
  assign row_cur      = row_valid[word_q] ? ram_rdata : row_reset(word_q);
  assign alloc_bit    = low_bit(row_cur);
  assign already_free = row_cur[bit_q];
  assign alloc_id     = base_id + ID_W'({word_q, alloc_bit});

  always_comb begin
    row_new     = row_cur;
    status_next = ST_IGNORED;
    result_next = '0;
    if (kind_q == KIND_ALLOC) begin
      if (miss_q) begin
        status_next = ST_EMPTY;
      end else begin
        row_new[alloc_bit] = 1'b0;
        status_next        = ST_ALLOC;
        result_next        = alloc_id;
      end
    end else if (!miss_q && !already_free) begin
      row_new[bit_q] = 1'b1;
      status_next    = ST_FREED;
    end
  end

  assign out_load = (state == S_MOD) && (!out_valid || !out_stall);
  assign ram_we   = out_load && !miss_q && ((kind_q == KIND_ALLOC) || !already_free);

  // Summary and written-row marks
  always_ff @(posedge clk) begin
    if (rst) begin
      summary   <= '1;
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[word_q] <= 1'b1;
      summary[word_q]   <= (row_new != '0);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = S_MOD;
      end
      S_MOD: begin
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_id <= result_next;
      status    <= status_next;
    end
  end

  // Every accepted word moves to the update cycle
  a_take_to_mod: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_MOD))
    else $error("accepted word did not enter update cycle");

  // Bitmap writes only when the result is loaded
  a_we_load: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_MOD) && out_load)
    else $error("bitmap written outside update cycle");

  // A word the summary marks non-empty really holds a free ID
  a_summary_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) && (kind_q == KIND_ALLOC) && !miss_q |-> (row_cur != '0))
    else $error("summary out of step with bitmap");

  // The held request stays put while the update cycle waits
  a_hold_req: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) && !out_load |=> $stable(word_q) && $stable(kind_q))
    else $error("held request changed while waiting");

endmodule
`default_nettype wire
